FILE: src/configurable_crc_engine_unit_macros.svh
// Assertion macros shared by the CRC engine RTL.
`ifndef CONFIGURABLE_CRC_ENGINE_UNIT_MACROS_SVH
`define CONFIGURABLE_CRC_ENGINE_UNIT_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define CRCE_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("crc engine assertion failed");

// Property checked on every clock edge, reset included.
`define CRCE_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("crc engine assertion failed");

`endif

FILE: src/crce_pkg.sv
// Shared constants, register index codes and helpers of the CRC engine.
`timescale 1ns / 1ps

package crce_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int CRC_OUT_W   = 32;
  localparam int WIDTH_REG_W = 6;

  // Register index codes of the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CRC_WIDTH   = 3'd0,
    CFG_POLY        = 3'd1,
    CFG_INIT_VALUE  = 3'd2,
    CFG_FINAL_XOR   = 3'd3,
    CFG_REFLECT_IN  = 3'd4,
    CFG_REFLECT_OUT = 3'd5
  } cfg_index_t;

  // Reset settings: CRC-16, x^16 + x^12 + x^5 + 1, zero init and final XOR.
  localparam logic [WIDTH_REG_W-1:0] RESET_CRC_WIDTH = 6'd16;
  localparam logic [31:0]            RESET_POLY      = 32'h0000_1021;

  // Byte bit reversal.
  function automatic logic [7:0] reverse8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

endpackage

FILE: src/configurable_crc_engine_unit.sv
// Top level of the configurable CRC engine: config registers, pipeline, handshakes.
`timescale 1ns / 1ps

// Configurable CRC engine, Rocksoft style, 8 to MAX_WIDTH bits. Send a message
// one byte per request on the slave side: tdata[7:0] is the byte, tuser[0]
// marks the first byte (remainder restarts from init_value) and tlast the
// last byte, which yields one CRC on the master side. Throughput is one byte
// per clock unless a last byte stalls: the byte goes into an input register,
// from which the eight unrolled reduction steps update the running remainder
// and, for a last byte, load the result register, so each CRC comes out of
// the result register. The input stage keeps taking bytes while a result
// waits; only a further last byte stalls until the result is taken. A byte
// without the first mark continues from the stored remainder. Widths below 8
// act as 8 and above MAX_WIDTH as MAX_WIDTH; poly and init_value bits above
// the width are ignored. Write configuration only while the engine is idle.
// Reset gives CRC-16 with polynomial 0x1021, zero init, zero final XOR and
// no reflection.

`include "configurable_crc_engine_unit_macros.svh"

module configurable_crc_engine_unit #(
  parameter int MAX_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [crce_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [crce_pkg::CFG_DATA_W-1:0]    cfg_data,
  // byte stream in
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,   // [7:0] data_byte
  input  logic [0:0]                         s_tuser,   // [0] first_byte
  input  logic                               s_tlast,   // last_byte
  // CRC results out
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [crce_pkg::CRC_OUT_W-1:0]     m_tdata    // [31:0] crc_value
);

  localparam int SHW = $clog2(MAX_WIDTH);
  localparam logic [crce_pkg::WIDTH_REG_W-1:0] MAX_W6 = crce_pkg::WIDTH_REG_W'(MAX_WIDTH);

  // Configuration registers
  logic [crce_pkg::WIDTH_REG_W-1:0] crc_width;
  logic [MAX_WIDTH-1:0]             poly;
  logic [MAX_WIDTH-1:0]             init_value;
  logic [MAX_WIDTH-1:0]             final_xor;
  logic                             reflect_in;
  logic                             reflect_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_width   <= crce_pkg::RESET_CRC_WIDTH;
      poly        <= MAX_WIDTH'(crce_pkg::RESET_POLY);
      init_value  <= '0;
      final_xor   <= '0;
      reflect_in  <= 1'b0;
      reflect_out <= 1'b0;
    end else if (cfg_we) begin
      case (crce_pkg::cfg_index_t'(cfg_index))
        crce_pkg::CFG_CRC_WIDTH:   crc_width   <= cfg_data[crce_pkg::WIDTH_REG_W-1:0];
        crce_pkg::CFG_POLY:        poly        <= cfg_data[MAX_WIDTH-1:0];
        crce_pkg::CFG_INIT_VALUE:  init_value  <= cfg_data[MAX_WIDTH-1:0];
        crce_pkg::CFG_FINAL_XOR:   final_xor   <= cfg_data[MAX_WIDTH-1:0];
        crce_pkg::CFG_REFLECT_IN:  reflect_in  <= cfg_data[0];
        crce_pkg::CFG_REFLECT_OUT: reflect_out <= cfg_data[0];
        default: ; // unused index, write dropped
      endcase
    end
  end

  // Effective width, saturated to 8..MAX_WIDTH, as shift and mask
  logic [crce_pkg::WIDTH_REG_W-1:0] eff_width;
  logic [SHW-1:0]                   shift;
  logic [MAX_WIDTH-1:0]             width_mask;

  always_comb begin
    if (crc_width < 6'd8) begin
      eff_width = 6'd8;
    end else if (crc_width > MAX_W6) begin
      eff_width = MAX_W6;
    end else begin
      eff_width = crc_width;
    end
    shift      = SHW'(MAX_W6 - eff_width);
    width_mask = {MAX_WIDTH{1'b1}} >> shift;
  end

  // Input register stage
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_first;
  logic       s1_last;
  logic       s1_adv;

  // A non-last byte always moves on; a last byte needs room in the result reg.
  assign s1_adv   = s1_valid && (!s1_last || !m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_byte  <= s_tdata;
      s1_first <= s_tuser[0];
      s1_last  <= s_tlast;
    end
  end

  // Remainder update
  logic [MAX_WIDTH-1:0] remainder;
  logic [MAX_WIDTH-1:0] remainder_next;
  logic [MAX_WIDTH-1:0] rem_start;

  assign rem_start = (s1_first ? init_value : remainder) & width_mask;

  crce_byte_step #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_step (
    .rem_in     (rem_start),
    .poly       (poly & width_mask),
    .shift      (shift),
    .data_byte  (s1_byte),
    .reflect_in (reflect_in),
    .rem_out    (remainder_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      remainder <= '0;
    end else if (s1_adv) begin
      remainder <= remainder_next;
    end
  end

  // Finish: reflect over the width (full reverse, then drop the pad), XOR, mask
  logic [MAX_WIDTH-1:0] rem_reversed;
  logic [MAX_WIDTH-1:0] crc_finished;

  always_comb begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      rem_reversed[i] = remainder_next[MAX_WIDTH-1-i];
    end
    crc_finished = ((reflect_out ? (rem_reversed >> shift) : remainder_next) ^ final_xor)
                   & width_mask;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last) begin
      m_tdata <= crce_pkg::CRC_OUT_W'(crc_finished);
    end
  end

  // Assertions
  `CRCE_ASSERT(a_last_blocks_when_full, s1_valid && s1_last && m_tvalid && !m_tready |-> !s_tready)
  `CRCE_ASSERT(a_last_gives_result, s1_adv && s1_last |=> m_tvalid)
  `CRCE_ASSERT_ALWAYS(a_reset_empties, rst |=> !s1_valid && !m_tvalid)

endmodule

FILE: src/crce_byte_step.sv
// One-byte CRC update: byte injection and eight unrolled reduction steps.
`timescale 1ns / 1ps

module crce_byte_step #(
  parameter int MAX_WIDTH = 32
) (
  input  logic [MAX_WIDTH-1:0]         rem_in,     // start remainder, masked to width
  input  logic [MAX_WIDTH-1:0]         poly,       // polynomial, masked to width
  input  logic [$clog2(MAX_WIDTH)-1:0] shift,      // MAX_WIDTH minus effective width
  input  logic [7:0]                   data_byte,
  input  logic                         reflect_in,
  output logic [MAX_WIDTH-1:0]         rem_out
);

  logic [MAX_WIDTH-1:0] rem_aligned;
  logic [MAX_WIDTH-1:0] poly_aligned;
  logic [7:0]           byte_in;

  // Work MSB-aligned so the top bit and the byte lane sit at fixed places.
  always_comb begin
    byte_in      = reflect_in ? crce_pkg::reverse8(data_byte) : data_byte;
    poly_aligned = poly << shift;
    rem_aligned  = rem_in << shift;
    rem_aligned[MAX_WIDTH-1 -: 8] = rem_aligned[MAX_WIDTH-1 -: 8] ^ byte_in;
    for (int i = 0; i < 8; i++) begin
      if (rem_aligned[MAX_WIDTH-1]) begin
        rem_aligned = (rem_aligned << 1) ^ poly_aligned;
      end else begin
        rem_aligned = rem_aligned << 1;
      end
    end
    rem_out = rem_aligned >> shift;
  end

endmodule
